[rtl/satl_pkg.sv]
// Shared types and constants of the set-associative cache tag lookup unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package satl_pkg;

  // Fixed geometry of the item fields
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned LINE_BYTES   = 32;
  localparam int unsigned OFF_W        = $clog2(LINE_BYTES);
  localparam int unsigned SETS_DEF     = 512;
  localparam int unsigned WAYS_DEF     = 4;
  localparam int unsigned LOAD_SET_W   = 9;
  localparam int unsigned LOAD_WAY_W   = 2;
  localparam int unsigned LOAD_TAG_W   = 18;
  localparam int unsigned OUT_WAY_W    = 2;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned SEED_W       = 16;
  localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(1);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_LOAD   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  // Input item
  typedef struct packed {
    opcode_e                 opcode;
    logic [ADDR_W-1:0]       address;
    logic [LOAD_SET_W-1:0]   load_set;
    logic [LOAD_WAY_W-1:0]   load_way;
    logic                    load_valid;
    logic [LOAD_TAG_W-1:0]   load_tag;
  } req_t;

  // Result item
  typedef struct packed {
    logic                    hit;
    logic [OUT_WAY_W-1:0]    way;
    logic [CNT_W-1:0]        hit_total;
    logic [CNT_W-1:0]        miss_total;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch item, read its tag row
    logic execute;   // compare, write back, emit result
    logic clear;     // clear one row of the valid bits
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } stat_t;

  // Next state of the victim LFSR, x^16+x^14+x^13+x^11+1, shifting right
  function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] r);
    logic fb;
    fb = r[0] ^ r[2] ^ r[3] ^ r[5];
    return {fb, r[SEED_W-1:1]};
  endfunction

endpackage

[rtl/satl_ctrl.sv]
// Sequencing controller of the tag lookup unit: clearing pass, accept, execute.
// Depends on satl_pkg.
`timescale 1ns / 1ps

module satl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  satl_pkg::stat_t stat_i,
  output satl_pkg::cmd_t  cmd_o,
  output logic            busy_o
);
  import satl_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/satl_dpath.sv]
// Datapath of the tag lookup unit: tag array, compare, victim LFSR, counters.
// Depends on satl_pkg; driven by satl_ctrl through cmd_t and stat_t.
`timescale 1ns / 1ps

module satl_dpath #(
  parameter int unsigned SETS = satl_pkg::SETS_DEF,
  parameter int unsigned WAYS = satl_pkg::WAYS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  satl_pkg::cmd_t                 cmd_i,
  output satl_pkg::stat_t                stat_o,
  input  satl_pkg::req_t                 req_i,
  input  logic                           cfg_we_i,
  input  logic [satl_pkg::SEED_W-1:0]    cfg_wdata_i,
  output satl_pkg::rsp_t                 rsp_o,
  output logic                           done_o
);
  import satl_pkg::*;

  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned WAY_W = $clog2(WAYS);
  localparam int unsigned TAG_W = ADDR_W - OFF_W - SET_W;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // Tag array: one row per set, per-way write mask
  row_t mem_q [SETS];

  req_t                item_q;
  row_t                row_q;
  logic [SET_W-1:0]    clr_idx_q;
  logic [SEED_W-1:0]   lfsr_q;
  logic [CNT_W-1:0]    hits_q, misses_q;
  rsp_t                rsp_q;
  logic                done_q;

  logic [SET_W-1:0]    look_set, wr_addr;
  logic [TAG_W-1:0]    look_tag;
  logic                found;
  logic [WAY_W-1:0]    hit_way, victim, load_way;
  logic [WAYS-1:0]     wr_mask;
  row_t                wr_row;
  logic                miss;

  assign look_set = item_q.address[OFF_W +: SET_W];
  assign look_tag = item_q.address[ADDR_W-1 -: TAG_W];
  assign victim   = WAY_W'(lfsr_q);
  assign load_way = WAY_W'(item_q.load_way);

  // Lowest valid matching way wins
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_q[w].valid && row_q[w].tag == look_tag) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign miss = cmd_i.execute && (item_q.opcode == OP_LOOKUP) && !found;

  // Select the row write: clearing pass, load, or miss fill
  always_comb begin
    wr_addr = look_set;
    wr_mask = '0;
    wr_row  = '0;
    if (cmd_i.clear) begin
      wr_addr = clr_idx_q;
      wr_mask = '1;
    end else if (cmd_i.execute) begin
      if (item_q.opcode == OP_LOAD) begin
        wr_addr           = SET_W'(item_q.load_set);
        wr_mask[load_way] = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          wr_row[w].valid = item_q.load_valid;
          wr_row[w].tag   = TAG_W'(item_q.load_tag);
        end
      end else if (!found) begin
        wr_mask[victim] = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          wr_row[w].valid = 1'b1;
          wr_row[w].tag   = look_tag;
        end
      end
    end
  end

  // Write the tag array
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < WAYS; w++) begin
      if (wr_mask[w]) begin
        mem_q[wr_addr][w] <= wr_row[w];
      end
    end
  end

  // Latch the item and read its tag row
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= req_i;
      row_q  <= mem_q[req_i.address[OFF_W +: SET_W]];
    end
  end

  // Advance the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + SET_W'(1);
    end
  end

  assign stat_o.clear_last = (clr_idx_q == SET_W'(SETS - 1));

  // Load the seed on a write, else step the LFSR on each miss
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= SEED_RESET;
    end else if (cfg_we_i) begin
      lfsr_q <= (cfg_wdata_i == '0) ? SEED_RESET : cfg_wdata_i;
    end else if (miss) begin
      lfsr_q <= lfsr_next(lfsr_q);
    end
  end

  // Count hits and misses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else if (cmd_i.execute && item_q.opcode == OP_LOOKUP) begin
      if (found) begin
        hits_q <= hits_q + CNT_W'(1);
      end else begin
        misses_q <= misses_q + CNT_W'(1);
      end
    end
  end

  // Register the result item and its strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.execute;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      rsp_q.hit <= (item_q.opcode == OP_LOOKUP) && found;
      if (item_q.opcode == OP_LOAD) begin
        rsp_q.way        <= OUT_WAY_W'(load_way);
        rsp_q.hit_total  <= hits_q;
        rsp_q.miss_total <= misses_q;
      end else if (found) begin
        rsp_q.way        <= OUT_WAY_W'(hit_way);
        rsp_q.hit_total  <= hits_q + CNT_W'(1);
        rsp_q.miss_total <= misses_q;
      end else begin
        rsp_q.way        <= OUT_WAY_W'(victim);
        rsp_q.hit_total  <= hits_q;
        rsp_q.miss_total <= misses_q + CNT_W'(1);
      end
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

[rtl/set_assoc_cache_tag_lookup_unit.sv]
// Tag store of a set-associative cache with random replacement and hit/miss
// counters. After reset the unit holds busy_o high while it clears the valid
// bits one set per cycle; a seed write is taken during that time as ever.
// Each item is accepted in the idle state, in which busy_o is low, and is then
// executed in a state with busy_o high (start_i is sampled only while busy_o
// is low, so a new item is not taken before the last one has executed):
// the accept edge reads the set's tag row from the single-port tag array and
// the next edge compares, writes back a fill or load, and updates the
// counters. The result appears on rsp_o with done_o high for exactly one
// cycle, the cycle after that, and cannot be held off by the receiver.
// SETS, WAYS and the line size must be powers of two; the block does not check.
// Depends on satl_pkg, satl_ctrl and satl_dpath.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_unit #(
  parameter int unsigned SETS = satl_pkg::SETS_DEF,
  parameter int unsigned WAYS = satl_pkg::WAYS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  satl_pkg::req_t              req_i,
  input  logic                        cfg_we_i,
  input  logic [satl_pkg::SEED_W-1:0] cfg_wdata_i,
  output logic                        done_o,
  output satl_pkg::rsp_t              rsp_o
);
  import satl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  satl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  satl_dpath #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rsp_o      (rsp_o),
    .done_o     (done_o)
  );

endmodule

[dv/set_assoc_cache_tag_lookup_unit_test.sv]
// Self-checking testbench of the cache tag lookup unit: random and directed
// lookups and way loads, checked against an in-bench model of the tag store.
// Depends on satl_pkg and set_assoc_cache_tag_lookup_unit.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_unit_test;
  import satl_pkg::*;

  localparam int unsigned WAYS      = WAYS_DEF;
  localparam int unsigned SETS      = SETS_DEF;
  localparam int unsigned SET_POOL  = 16;
  localparam int unsigned TAG_POOL  = 8;
  localparam int unsigned PHASE_LEN = 250;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic              busy_o;
  req_t              req_i       = '0;
  logic              cfg_we_i    = 1'b0;
  logic [SEED_W-1:0] cfg_wdata_i = '0;
  logic              done_o;
  rsp_t              rsp_o;

  set_assoc_cache_tag_lookup_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  // Mirror of the tag store, counters and victim LFSR
  bit                    way_valid [SETS*WAYS];
  logic [LOAD_TAG_W-1:0] way_tag   [SETS*WAYS];
  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;
  logic [SEED_W-1:0]     victim_lfsr;

  req_t access_q [$];
  rsp_t outcome_q [$];
  bit   item_taken;
  int   mismatches;

  logic [LOAD_SET_W-1:0] set_pool [SET_POOL];
  logic [LOAD_TAG_W-1:0] tag_pool [TAG_POOL];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("set_assoc_cache_tag_lookup_unit: mismatch");
    $finish;
  end

  // Apply one item to the mirrored state and return the result it causes
  function automatic rsp_t predict_access(input req_t r);
    rsp_t                  o;
    int                    base;
    logic [LOAD_TAG_W-1:0] tag;
    logic [1:0]            victim;
    bit                    found;
    o = '0;
    if (r.opcode == OP_LOAD) begin
      base = int'(r.load_set) * WAYS + int'(r.load_way);
      way_valid[base] = r.load_valid;
      way_tag[base] = r.load_tag;
      o.way = r.load_way;
    end else begin
      base = int'(r.address[OFF_W +: LOAD_SET_W]) * WAYS;
      tag = r.address[ADDR_W-1 -: LOAD_TAG_W];
      found = 1'b0;
      // lowest valid matching way wins
      for (int w = 0; w < WAYS; w++) begin
        if (!found && way_valid[base+w] && way_tag[base+w] == tag) begin
          found = 1'b1;
          o.way = OUT_WAY_W'(w);
        end
      end
      if (found) begin
        o.hit = 1'b1;
        hit_count = hit_count + CNT_W'(1);
      end else begin
        // fill the victim, then step the LFSR
        victim = victim_lfsr[1:0];
        way_valid[base+victim] = 1'b1;
        way_tag[base+victim] = tag;
        miss_count = miss_count + CNT_W'(1);
        victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                       victim_lfsr[SEED_W-1:1]};
        o.way = victim;
      end
    end
    o.hit_total = hit_count;
    o.miss_total = miss_count;
    return o;
  endfunction

  function automatic req_t mk_lookup(input logic [LOAD_TAG_W-1:0] tag,
                                     input logic [LOAD_SET_W-1:0] set_ix,
                                     input logic [OFF_W-1:0] off);
    req_t r;
    r = '0;
    r.opcode = OP_LOOKUP;
    r.address = {tag, set_ix, off};
    return r;
  endfunction

  function automatic req_t mk_load(input logic [LOAD_SET_W-1:0] set_ix,
                                   input logic [LOAD_WAY_W-1:0] way_ix,
                                   input logic valid,
                                   input logic [LOAD_TAG_W-1:0] tag);
    req_t r;
    r = '0;
    r.opcode = OP_LOAD;
    r.load_set = set_ix;
    r.load_way = way_ix;
    r.load_valid = valid;
    r.load_tag = tag;
    return r;
  endfunction

  // Mostly lookups into a few preloaded sets with recurring tags, so hits,
  // misses and evictions all show up; a share of way loads on top
  function automatic req_t random_access();
    req_t        r;
    int unsigned pick;
    r.address = $urandom;
    r.load_set = LOAD_SET_W'($urandom_range(0, SETS - 1));
    r.load_way = LOAD_WAY_W'($urandom_range(0, WAYS - 1));
    r.load_valid = 1'($urandom_range(0, 1));
    r.load_tag = LOAD_TAG_W'($urandom_range(0, (1 << LOAD_TAG_W) - 1));
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      r = mk_lookup(tag_pool[$urandom_range(0, TAG_POOL - 1)],
                    set_pool[$urandom_range(0, SET_POOL - 1)], OFF_W'($urandom));
    end else if (pick < 88) begin
      r.opcode = OP_LOOKUP;
      r.address[OFF_W +: LOAD_SET_W] = set_pool[$urandom_range(0, SET_POOL - 1)];
    end else begin
      r.opcode = OP_LOAD;
      if (pick < 96) begin
        r.load_set = set_pool[$urandom_range(0, SET_POOL - 1)];
        r.load_tag = tag_pool[$urandom_range(0, TAG_POOL - 1)];
        r.load_valid = ($urandom_range(0, 3) != 0);
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // Wait until every item has been taken and answered, then let the unit settle
  task automatic drain();
    do @(posedge clk_i);
    while (access_q.size() != 0 || start_i || outcome_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] seed);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= seed;
    // a zero seed loads as one
    victim_lfsr = (seed == '0) ? SEED_W'(1) : seed;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Feed items in bursts of random length separated by random gaps
  always @(negedge clk_i) begin : drive_items
    logic nxt_start;
    req_t nxt_req;
    int   gap_left;
    int   burst_left;
    nxt_start = start_i;
    nxt_req = req_i;
    if (start_i && item_taken) begin
      nxt_start = 1'b0;
      item_taken = 1'b0;
    end
    if (!nxt_start && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (access_q.size() != 0) begin
        nxt_req = access_q.pop_front();
        nxt_start = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
    start_i <= nxt_start;
    req_i <= nxt_req;
  end

  // Check results against the oldest prediction, then predict accepted items
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (outcome_q.size() == 0) begin
          note_mismatch("unexpected result, hit_total", '0, rsp_o.hit_total);
        end else begin
          want = outcome_q.pop_front();
          if (rsp_o.hit !== want.hit)
            note_mismatch("hit", CNT_W'(want.hit), CNT_W'(rsp_o.hit));
          if (rsp_o.way !== want.way)
            note_mismatch("way", CNT_W'(want.way), CNT_W'(rsp_o.way));
          if (rsp_o.hit_total !== want.hit_total)
            note_mismatch("hit_total", want.hit_total, rsp_o.hit_total);
          if (rsp_o.miss_total !== want.miss_total)
            note_mismatch("miss_total", want.miss_total, rsp_o.miss_total);
        end
      end
      if (start_i && busy_o === 1'b0) begin
        outcome_q.push_back(predict_access(req_i));
        item_taken = 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [SEED_W-1:0] seeds [5];
    for (int i = 0; i < SETS * WAYS; i++) begin
      way_valid[i] = 1'b0;
      way_tag[i] = '0;
    end
    hit_count = '0;
    miss_count = '0;
    victim_lfsr = SEED_RESET;
    item_taken = 1'b0;
    mismatches = 0;
    set_pool[0] = '0;
    set_pool[1] = '1;
    for (int i = 2; i < SET_POOL; i++)
      set_pool[i] = LOAD_SET_W'($urandom_range(0, SETS - 1));
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++)
      tag_pool[i] = LOAD_TAG_W'($urandom_range(0, (1 << LOAD_TAG_W) - 1));
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = 16'h8000;
    seeds[3] = SEED_W'($urandom_range(1, 65535));
    seeds[4] = 16'h0001;

    // hold reset, then wait out the clearing pass
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (busy_o !== 1'b0);

    // write every way of the pooled sets before any lookup reads them
    for (int s = 0; s < SET_POOL; s++)
      for (int w = 0; w < WAYS; w++)
        access_q.push_back(mk_load(set_pool[s], LOAD_WAY_W'(w), 1'($urandom_range(0, 1)),
                                   tag_pool[$urandom_range(0, TAG_POOL - 1)]));

    // directed: field extremes, multiple matches, invalidation, eviction
    access_q.push_back(mk_load('0, 2'd0, 1'b1, '0));
    access_q.push_back(mk_lookup('0, '0, '0));
    access_q.push_back(mk_load('1, 2'd3, 1'b1, '1));
    access_q.push_back(mk_lookup('1, '1, '1));
    access_q.push_back(mk_load('0, 2'd2, 1'b1, 18'h00155));
    access_q.push_back(mk_load('0, 2'd1, 1'b1, 18'h00155));
    access_q.push_back(mk_lookup(18'h00155, '0, 5'h0a));
    access_q.push_back(mk_load('0, 2'd1, 1'b0, 18'h00155));
    access_q.push_back(mk_lookup(18'h00155, '0, 5'h15));
    access_q.push_back(mk_lookup(18'h2aaaa, '0, '0));
    access_q.push_back(mk_lookup(18'h2aaaa, '0, '1));
    for (int i = 0; i < 6; i++)
      access_q.push_back(mk_lookup(LOAD_TAG_W'(18'h10000 + i), '1, '0));
    access_q.push_back(mk_lookup(18'h10000, '1, '0));
    access_q.push_back(mk_load('0, 2'd0, 1'b0, '1));
    access_q.push_back(mk_lookup('0, '0, '0));

    for (int i = 0; i < PHASE_LEN; i++) access_q.push_back(random_access());
    foreach (seeds[k]) begin
      write_seed(seeds[k]);
      for (int i = 0; i < PHASE_LEN; i++) access_q.push_back(random_access());
    end

    drain();
    mismatches += outcome_q.size();
    if (mismatches == 0) begin
      $display("set_assoc_cache_tag_lookup_unit: match");
    end else begin
      $display("set_assoc_cache_tag_lookup_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/satl_pkg.sv
rtl/satl_ctrl.sv
rtl/satl_dpath.sv
rtl/set_assoc_cache_tag_lookup_unit.sv
dv/set_assoc_cache_tag_lookup_unit_test.sv
